### rtl/core/b64d_pkg.sv
package b64d_pkg;

    // One character step releases at most one group. A non-space character
    // releases the held group, and the end of the message releases the held
    // group with its padding removed. A character that completes a group
    // cannot also release an older one, because three non-space characters
    // always come between two completed groups.
    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned CNT_W       = 3;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CHAR_D0    = 8'h30;
    localparam logic [7:0] CHAR_D9    = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    // Offsets that move a character code onto its sextet value (mod 256).
    localparam logic [7:0] OFS_UC    = 8'h41;   // 'A' -> 0
    localparam logic [7:0] OFS_LC    = 8'h47;   // 'a' -> 26
    localparam logic [7:0] OFS_DIGIT = 8'h04;   // '0' -> 52, added

    typedef struct packed {
        logic [5:0] sextet;
        logic       blank;
        logic       pad;
    } b64d_char_t;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [MAX_RESULTS-1:0]      valid;
        logic [CNT_W-1:0]            count;
        logic                        done;
        logic                        err;
    } b64d_bundle_t;

endpackage

### rtl/core/b64d_map.sv
module b64d_map (
    input  logic [7:0]          char_in,
    output b64d_pkg::b64d_char_t char_info
);

    logic [7:0] diff;

    always_comb begin
        diff = 8'd0;
        char_info.sextet = 6'd0;
        if ((char_in >= b64d_pkg::CHAR_UC_A) && (char_in <= b64d_pkg::CHAR_UC_Z)) begin
            diff = char_in - b64d_pkg::OFS_UC;
            char_info.sextet = diff[5:0];
        end else if ((char_in >= b64d_pkg::CHAR_LC_A) && (char_in <= b64d_pkg::CHAR_LC_Z)) begin
            diff = char_in - b64d_pkg::OFS_LC;
            char_info.sextet = diff[5:0];
        end else if ((char_in >= b64d_pkg::CHAR_D0) && (char_in <= b64d_pkg::CHAR_D9)) begin
            diff = char_in + b64d_pkg::OFS_DIGIT;
            char_info.sextet = diff[5:0];
        end else if (char_in == b64d_pkg::CHAR_PLUS) begin
            char_info.sextet = b64d_pkg::SEXTET_PLUS;
        end else if (char_in == b64d_pkg::CHAR_SLASH) begin
            char_info.sextet = b64d_pkg::SEXTET_SLASH;
        end
        char_info.blank = (char_in == b64d_pkg::CHAR_SPACE) ||
                          ((char_in >= b64d_pkg::CHAR_TAB) && (char_in <= b64d_pkg::CHAR_CR));
        char_info.pad   = (char_in == b64d_pkg::CHAR_PAD);
    end

endmodule

### rtl/core/b64d_core.sv
module b64d_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_fire,
    input  logic [7:0]             in_char,
    input  logic                   in_last,
    output b64d_pkg::b64d_bundle_t bundle
);

    b64d_pkg::b64d_char_t ci;

    logic [17:0] partial_reg, partial_next;
    logic [1:0]  cig_reg, cig_next;
    logic        tpad_reg, tpad_next;
    logic [23:0] held_reg, held_next;
    logic        hv_reg, hv_next;
    logic [1:0]  hpc_reg, hpc_next;

    // State as it stands after the character, before the end-of-message clear.
    logic [17:0] partial_c;
    logic [1:0]  cig_c;
    logic        tpad_c;
    logic [23:0] held_c;
    logic        hv_c;
    logic [1:0]  hpc_c;
    logic        release_held;
    logic [2:0]  fin_cnt;
    logic [2:0]  total;

    b64d_map u_map (
        .char_in   (in_char),
        .char_info (ci)
    );

    always_comb begin
        partial_c    = partial_reg;
        cig_c        = cig_reg;
        tpad_c       = tpad_reg;
        held_c       = held_reg;
        hv_c         = hv_reg;
        hpc_c        = hpc_reg;
        release_held = 1'b0;
        if (!ci.blank) begin
            release_held = hv_reg;
            hv_c = 1'b0;
            if (cig_reg == 2'd2) begin
                tpad_c = ci.pad;
            end
            if (cig_reg == 2'd3) begin
                held_c    = {partial_reg, ci.sextet};
                hpc_c     = {1'b0, tpad_reg} + {1'b0, ci.pad};
                hv_c      = 1'b1;
                partial_c = 18'd0;
                cig_c     = 2'd0;
                tpad_c    = 1'b0;
            end else begin
                partial_c = {partial_reg[11:0], ci.sextet};
                cig_c     = cig_reg + 2'd1;
            end
        end

        // Final group loses one byte per '=' among its last two characters.
        // A released group leaves nothing held, so the two counts never add up.
        fin_cnt = 3'd0;
        if (in_last && hv_c) begin
            fin_cnt = 3'd3 - {1'b0, hpc_c};
        end
        total = (release_held ? 3'd3 : 3'd0) + fin_cnt;

        bundle.valid = '1;
        bundle.bytes = '0;
        if (release_held) begin
            bundle.bytes[0] = held_reg[23:16];
            bundle.bytes[1] = held_reg[15:8];
            bundle.bytes[2] = held_reg[7:0];
        end else begin
            bundle.bytes[0] = held_c[23:16];
            bundle.bytes[1] = held_c[15:8];
            bundle.bytes[2] = held_c[7:0];
        end
        bundle.count = total;
        bundle.done  = in_last;
        bundle.err   = in_last && (cig_c != 2'd0);
        if (in_last && (total == 3'd0)) begin
            // Nothing to release: a single empty result closes the message.
            bundle.count    = 3'd1;
            bundle.valid[0] = 1'b0;
            bundle.bytes[0] = 8'd0;
        end

        partial_next = partial_reg;
        cig_next     = cig_reg;
        tpad_next    = tpad_reg;
        held_next    = held_reg;
        hv_next      = hv_reg;
        hpc_next     = hpc_reg;
        if (in_fire) begin
            if (in_last) begin
                partial_next = 18'd0;
                cig_next     = 2'd0;
                tpad_next    = 1'b0;
                held_next    = 24'd0;
                hv_next      = 1'b0;
                hpc_next     = 2'd0;
            end else begin
                partial_next = partial_c;
                cig_next     = cig_c;
                tpad_next    = tpad_c;
                held_next    = held_c;
                hv_next      = hv_c;
                hpc_next     = hpc_c;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= 18'd0;
            cig_reg     <= 2'd0;
            tpad_reg    <= 1'b0;
            held_reg    <= 24'd0;
            hv_reg      <= 1'b0;
            hpc_reg     <= 2'd0;
        end else begin
            partial_reg <= partial_next;
            cig_reg     <= cig_next;
            tpad_reg    <= tpad_next;
            held_reg    <= held_next;
            hv_reg      <= hv_next;
            hpc_reg     <= hpc_next;
        end
    end

endmodule

### rtl/core/b64d_out.sv
module b64d_out (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  b64d_pkg::b64d_bundle_t bundle,
    output logic                   can_load,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast,
    output logic [1:0]             m_tuser
);

    logic [b64d_pkg::MAX_RESULTS-1:0][7:0] bytes_reg, bytes_next;
    logic [b64d_pkg::MAX_RESULTS-1:0]      valid_reg, valid_next;
    logic [b64d_pkg::CNT_W-1:0]            cnt_reg, cnt_next;
    logic                                  done_reg, done_next;
    logic                                  err_reg, err_next;
    logic                                  pop;
    logic                                  on_last;

    assign pop      = m_tvalid && m_tready;
    assign on_last  = (cnt_reg == 3'd1);
    assign can_load = (cnt_reg == 3'd0) || (on_last && m_tready);

    assign m_tvalid   = (cnt_reg != 3'd0);
    assign m_tdata    = bytes_reg[0];
    assign m_tlast    = done_reg && on_last;
    assign m_tuser[0] = valid_reg[0];
    assign m_tuser[1] = err_reg && on_last;

    always_comb begin
        bytes_next = bytes_reg;
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        done_next  = done_reg;
        err_next   = err_reg;
        if (load) begin
            bytes_next = bundle.bytes;
            valid_next = bundle.valid;
            cnt_next   = bundle.count;
            done_next  = bundle.done;
            err_next   = bundle.err;
        end else if (pop) begin
            for (int i = 0; i < b64d_pkg::MAX_RESULTS - 1; i++) begin
                bytes_next[i] = bytes_reg[i+1];
                valid_next[i] = valid_reg[i+1];
            end
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            err_reg  <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
        valid_reg <= valid_next;
    end

endmodule

### rtl/core/base64_stream_decoder.sv
// Channel   Direction  tdata               tuser                           tlast
// s_        in         [7:0] text_char     -                               end_of_text
// m_        out        [7:0] out_byte      [0] byte_valid [1] length_error message_done
//
// A request on s_ is decoded in the cycle it is accepted; its results are
// registered and appear on m_ from the next cycle, one byte per cycle while
// m_tready is high. A character yields zero to three results, so with m_tready
// high the block takes one character per cycle while each yields at most one;
// a group's release holds s_tready low until all but its last byte are taken.
// Reset (aresetn low at a clock edge) clears the group state and the buffer.
// A stall on m_ holds the current result stable and stops new requests once
// the result buffer cannot be refilled.
module base64_stream_decoder (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_char
    input  logic       s_tlast,   // end_of_text

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] byte_valid, [1] length_error
    output logic       m_tlast    // message_done
);

    b64d_pkg::b64d_bundle_t bundle;
    logic                   in_fire;
    logic                   can_load;

    // The result buffer takes a new bundle once empty or handing over its final
    // entry, so one character per cycle keeps flowing while m_tready is high.
    assign s_tready = can_load;
    assign in_fire  = s_tvalid && s_tready;

    // Group assembly: sextet mapping, the partial group and the held group.
    b64d_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_char (s_tdata),
        .in_last (s_tlast),
        .bundle  (bundle)
    );

    // Result register that spreads a bundle of bytes over the output channel.
    b64d_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (in_fire),
        .bundle   (bundle),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
